### src/rgbe_pkg.sv
// Shared types and constants of the RGBE run-length scanline decoder.
package rgbe_pkg;

  typedef enum logic [2:0] {
    PH_MARK_A, PH_MARK_B, PH_LEN_HI, PH_LEN_LO, PH_COUNT, PH_RUN, PH_LIT
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_RUN_RD, ST_RUN_WR, ST_LIT_WR, ST_EMIT, ST_ERR
  } seq_t;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MARKER   = 3'd1;
  localparam logic [2:0] ERR_LENGTH   = 3'd2;
  localparam logic [2:0] ERR_ZERO     = 3'd3;
  localparam logic [2:0] ERR_OVERRUN  = 3'd4;

  localparam logic [0:0] REG_WIDTH  = 1'b0;
  localparam logic [0:0] REG_HEIGHT = 1'b1;

  localparam logic [7:0] ROW_MARK = 8'd2;

  typedef struct packed {
    logic [31:0] first_red;
    logic [31:0] first_green;
    logic [31:0] first_blue;
    logic [31:0] second_red;
    logic [31:0] second_green;
    logic [31:0] second_blue;
    logic [1:0]  pixel_count;
    logic        last_of_run;
    logic        row_done;
    logic        frame_done;
    logic [2:0]  error_code;
  } result_t;

  // Converts one 8-bit mantissa and shared exponent to IEEE single bits.
  function automatic logic [31:0] rgbe_bits(input logic [7:0] m, input logic [7:0] e);
    logic [2:0]  p;
    logic signed [10:0] ex;
    logic [31:0] r;
    p = 3'd0;
    for (int i = 1; i < 8; i++) if (m[i]) p = 3'(i);
    ex = $signed({8'd0, p}) + $signed({3'd0, e}) - 11'sd136;
    if (m == 8'd0) r = 32'd0;
    else if (ex >= -11'sd126)
      r = {1'b0, 8'(ex + 11'sd127), 23'(({15'd0, m} << (5'd23 - 5'(p))))};
    else r = 32'({24'd0, m} << (6'(e) + 6'd13));
    return r;
  endfunction

endpackage

### src/rgbe_stream_if.sv
// Valid/ready channel carrying one payload word.
interface rgbe_stream_if #(parameter int W = 8);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rgbe_res_if.sv
// Valid/ready channel carrying one decoded result.
interface rgbe_res_if import rgbe_pkg::*; ();
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rgbe_rle_scanline_decoder.sv
// Top level of the RGBE run-length scanline decoder.
// One byte is taken per word. Header and count bytes are handled in ST_IDLE, a
// literal R, G or B byte in ST_LIT_WR, a literal E byte in ST_RUN_RD, ST_RUN_WR
// and ST_EMIT, with any wait for its result word to be taken. A run reads and
// writes each pixel through the single line store port; in the E plane each
// result word, of up to a pixel pair, passes ST_EMIT. An error sends one error
// word and halts the block until reset, which does not clear the line store.
module rgbe_rle_scanline_decoder import rgbe_pkg::*; #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [0:0]        cfg_index,
  input  logic [15:0]       cfg_data,
  rgbe_stream_if.sink       data_in,
  rgbe_res_if.source        result_out
);
  localparam int AW = $clog2(MAX_WIDTH);

  logic [10:0] image_width, image_width_next;
  logic [15:0] image_height, image_height_next;
  phase_t      phase, phase_next;
  logic [1:0]  plane_index, plane_index_next;
  logic [10:0] pixel_position, pixel_position_next;
  logic [7:0]  span_remaining, span_remaining_next;
  logic [7:0]  length_high, length_high_next;
  logic [15:0] row_counter, row_counter_next;
  logic        halted, halted_next;
  seq_t        st, st_next;
  logic [7:0]  cur_byte, cur_byte_next;
  logic        half, half_next;          // one pixel already held in the result word
  logic        run_end, run_end_next;    // the byte is finished once this word goes
  result_t     res, res_next;
  logic        out_valid, out_valid_next;

  logic [23:0] store [MAX_WIDTH];
  logic [23:0] rd_data;
  logic        st_we;
  logic [23:0] st_wdata;

  logic        fin, done, rdone, fdone;
  logic [10:0] pos_inc;
  logic [15:0] rc;
  logic [31:0] conv_r, conv_g, conv_b;

  wire [AW-1:0] addr = AW'(pixel_position);
  wire over = (pixel_position >= image_width) || ({5'd0, pixel_position} >= 16'(MAX_WIDTH));
  wire acc = data_in.valid && data_in.ready;

  assign pos_inc = pixel_position + 11'd1;
  assign rc = row_counter + 16'd1;
  assign fin = (span_remaining == 8'd1);
  // A literal byte writes one pixel only, so its result word is its last.
  assign done = fin || (phase == PH_LIT);
  assign conv_r = rgbe_bits(rd_data[23:16], cur_byte);
  assign conv_g = rgbe_bits(rd_data[15:8], cur_byte);
  assign conv_b = rgbe_bits(rd_data[7:0], cur_byte);

  assign data_in.ready = (st == ST_IDLE) && !out_valid;
  assign result_out.valid = out_valid;
  assign result_out.data = res;

  always_ff @(posedge clk) begin
    if (st_we) store[addr] <= st_wdata;
    rd_data <= store[addr];
  end

  always_comb begin
    st_next = st;
    image_width_next = image_width;
    image_height_next = image_height;
    phase_next = phase;
    plane_index_next = plane_index;
    pixel_position_next = pixel_position;
    span_remaining_next = span_remaining;
    length_high_next = length_high;
    row_counter_next = row_counter;
    halted_next = halted;
    cur_byte_next = cur_byte;
    half_next = half;
    run_end_next = run_end;
    res_next = res;
    out_valid_next = out_valid;
    rdone = 1'b0;
    fdone = 1'b0;
    if (cfg_we) begin
      if (cfg_index == REG_WIDTH) image_width_next = cfg_data[10:0];
      else image_height_next = cfg_data;
    end
    if (out_valid && result_out.ready) out_valid_next = 1'b0;
    unique case (st)
      ST_IDLE: if (acc && !halted) begin
        cur_byte_next = data_in.data;
        half_next = 1'b0;
        run_end_next = 1'b0;
        res_next = '0;
        unique case (phase)
          PH_MARK_A, PH_MARK_B:
            if (data_in.data != ROW_MARK) begin
              res_next.error_code = ERR_MARKER; res_next.last_of_run = 1'b1;
              out_valid_next = 1'b1; halted_next = 1'b1;
            end else phase_next = (phase == PH_MARK_A) ? PH_MARK_B : PH_LEN_HI;
          PH_LEN_HI: begin
            length_high_next = data_in.data; phase_next = PH_LEN_LO;
          end
          PH_LEN_LO:
            if (image_width == 11'd0 || {5'd0, image_width} > 16'(MAX_WIDTH) ||
                {length_high, data_in.data} != {5'd0, image_width}) begin
              res_next.error_code = ERR_LENGTH; res_next.last_of_run = 1'b1;
              out_valid_next = 1'b1; halted_next = 1'b1;
            end else begin
              phase_next = PH_COUNT; plane_index_next = 2'd0; pixel_position_next = 11'd0;
            end
          PH_COUNT:
            if (data_in.data == 8'd0) begin
              res_next.error_code = ERR_ZERO; res_next.last_of_run = 1'b1;
              out_valid_next = 1'b1; halted_next = 1'b1;
            end else if (data_in.data[7] && data_in.data[6:0] != 7'd0) begin
              span_remaining_next = {1'b0, data_in.data[6:0]}; phase_next = PH_RUN;
            end else begin
              span_remaining_next = data_in.data; phase_next = PH_LIT;
            end
          PH_RUN: st_next = ST_RUN_RD;
          PH_LIT: st_next = (plane_index == 2'd3) ? ST_RUN_RD : ST_LIT_WR;
          default: begin
            phase_next = PH_MARK_A;
            res_next.error_code = ERR_MARKER; res_next.last_of_run = 1'b1;
            out_valid_next = 1'b1; halted_next = 1'b1;
          end
        endcase
      end
      ST_RUN_RD: st_next = ST_RUN_WR;
      ST_LIT_WR, ST_RUN_WR: begin
        if (over) begin
          // Flush any held pixel, then the error word.
          halted_next = 1'b1;
          span_remaining_next = 8'd0;
          out_valid_next = 1'b1;
          if (half) st_next = ST_ERR;
          else begin
            res_next = '0; res_next.error_code = ERR_OVERRUN; res_next.last_of_run = 1'b1;
            st_next = ST_IDLE;
          end
        end else begin
          pixel_position_next = pos_inc;
          span_remaining_next = span_remaining - 8'd1;
          if (fin) begin
            phase_next = PH_COUNT;
            if (pos_inc == image_width) begin
              pixel_position_next = 11'd0;
              if (plane_index != 2'd3) plane_index_next = plane_index + 2'd1;
              else begin
                plane_index_next = 2'd0;
                phase_next = PH_MARK_A;
                rdone = 1'b1;
                if (rc == image_height) begin
                  fdone = 1'b1;
                  row_counter_next = 16'd0;
                end else row_counter_next = rc;
              end
            end
          end
          if (plane_index != 2'd3) begin
            st_next = (st == ST_RUN_WR && !fin) ? ST_RUN_RD : ST_IDLE;
          end else begin
            if (!half) begin
              res_next.first_red = conv_r; res_next.first_green = conv_g;
              res_next.first_blue = conv_b; res_next.pixel_count = 2'd1;
            end else begin
              res_next.second_red = conv_r; res_next.second_green = conv_g;
              res_next.second_blue = conv_b; res_next.pixel_count = 2'd2;
            end
            res_next.row_done = rdone; res_next.frame_done = fdone;
            res_next.last_of_run = done;
            run_end_next = done;
            if (half || done) begin
              out_valid_next = 1'b1; st_next = ST_EMIT;
            end else st_next = ST_RUN_RD;
            half_next = !(half || done);
          end
        end
      end
      ST_EMIT: if (!out_valid || result_out.ready) begin
        if (run_end) st_next = ST_IDLE;
        else begin
          res_next = '0; st_next = ST_RUN_RD;
        end
      end
      ST_ERR: if (!out_valid || result_out.ready) begin
        res_next = '0; res_next.error_code = ERR_OVERRUN; res_next.last_of_run = 1'b1;
        out_valid_next = 1'b1; st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_comb begin
    st_we = 1'b0;
    st_wdata = rd_data;
    if ((st == ST_RUN_WR || st == ST_LIT_WR) && !over && plane_index != 2'd3) begin
      st_we = 1'b1;
      unique case (plane_index)
        2'd0: st_wdata = {cur_byte, rd_data[15:0]};
        2'd1: st_wdata = {rd_data[23:16], cur_byte, rd_data[7:0]};
        default: st_wdata = {rd_data[23:8], cur_byte};
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= 11'd768; image_height <= 16'd1024;
      phase <= PH_MARK_A; plane_index <= 2'd0; pixel_position <= 11'd0;
      span_remaining <= 8'd0; length_high <= 8'd0; row_counter <= 16'd0;
      halted <= 1'b0; st <= ST_IDLE; out_valid <= 1'b0; half <= 1'b0;
      run_end <= 1'b0;
    end else begin
      image_width <= image_width_next; image_height <= image_height_next;
      phase <= phase_next; plane_index <= plane_index_next;
      pixel_position <= pixel_position_next;
      span_remaining <= span_remaining_next; length_high <= length_high_next;
      row_counter <= row_counter_next;
      halted <= halted_next; st <= st_next; out_valid <= out_valid_next;
      half <= half_next; run_end <= run_end_next;
    end
    cur_byte <= cur_byte_next;
    res <= res_next;
  end

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.error_code != ERR_NONE && result_out.ready) |=> halted)
    else $error("error word without halt");
  a_err_empty: assert property (@(posedge clk) disable iff (rst)
    (out_valid && res.error_code != ERR_NONE) |-> (res.pixel_count == 2'd0))
    else $error("error word carries pixels");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    (st != ST_IDLE) |-> !data_in.ready)
    else $error("input taken while busy");
endmodule

### tb/rgbe_rle_scanline_decoder_tb.sv
// Self-checking testbench of the RGBE run-length scanline decoder.
module rgbe_rle_scanline_decoder_tb;
  import rgbe_pkg::*;

  localparam int MAX_W = 1024;
  localparam longint CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = REG_WIDTH;
  logic [15:0] cfg_data = '0;

  rgbe_stream_if #(.W(8)) byte_ch ();
  rgbe_res_if             res_ch ();

  rgbe_rle_scanline_decoder #(.MAX_WIDTH(MAX_W)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .data_in(byte_ch.sink), .result_out(res_ch.source)
  );

  always #6 clk = ~clk;

  // Predictor state.
  int unsigned width_q, height_q;
  phase_t      phase_q;
  int unsigned plane_q, pos_q, span_q, len_hi_q, rows_q;
  bit          halted_q;
  logic [23:0] line_q [MAX_W];

  result_t pending_words [$];
  int      errors = 0;
  longint  cycles = 0;
  int      bytes_sent = 0, words_seen = 0;

  function automatic logic [31:0] to_float(input logic [7:0] m, input logic [7:0] e);
    int p, ex;
    p = 0;
    if (m == 0) return 32'd0;
    while (p < 7 && (m >> (p + 1)) != 0) p++;
    ex = p + int'(e) - 136;
    if (ex >= -126) return {1'b0, 8'(ex + 127), 23'((32'(m) << (23 - p)) & 32'h7FFFFF)};
    return 32'(m) << (e + 13);
  endfunction

  task automatic add_pixel(inout result_t words [$], inout bit open,
                           input logic [23:0] rgb, input logic [7:0] e);
    result_t w;
    if (open) begin
      w = words[$];
      void'(words.pop_back());
      w.second_red = to_float(rgb[23:16], e);
      w.second_green = to_float(rgb[15:8], e);
      w.second_blue = to_float(rgb[7:0], e);
      w.pixel_count = 2;
      words.push_back(w);
      open = 0;
    end else begin
      w = '0;
      w.first_red = to_float(rgb[23:16], e);
      w.first_green = to_float(rgb[15:8], e);
      w.first_blue = to_float(rgb[7:0], e);
      w.pixel_count = 1;
      words.push_back(w);
      open = 1;
    end
  endtask

  task automatic store_byte(input logic [7:0] v, inout result_t words [$], inout bit open,
                            output bit ok);
    ok = 0;
    if (pos_q >= width_q || pos_q >= MAX_W) return;
    case (plane_q)
      0: line_q[pos_q][23:16] = v;
      1: line_q[pos_q][15:8] = v;
      2: line_q[pos_q][7:0] = v;
      default: add_pixel(words, open, line_q[pos_q], v);
    endcase
    pos_q++;
    ok = 1;
  endtask

  task automatic close_span(inout bit row_end, inout bit frame_end);
    phase_q = PH_COUNT;
    if (pos_q != width_q) return;
    pos_q = 0;
    if (plane_q < 3) begin
      plane_q++;
      return;
    end
    plane_q = 0;
    phase_q = PH_MARK_A;
    row_end = 1;
    rows_q = (rows_q + 1) & 16'hFFFF;
    if (rows_q == height_q) begin
      frame_end = 1;
      rows_q = 0;
    end
  endtask

  task automatic predict_byte(input logic [7:0] b);
    result_t words [$];
    result_t w;
    bit open, row_end, frame_end, ok;
    logic [2:0] err;
    int unsigned len;
    open = 0; row_end = 0; frame_end = 0; err = ERR_NONE;
    if (halted_q) return;
    case (phase_q)
      PH_MARK_A, PH_MARK_B:
        if (b != ROW_MARK) err = ERR_MARKER;
        else phase_q = (phase_q == PH_MARK_A) ? PH_MARK_B : PH_LEN_HI;
      PH_LEN_HI: begin
        len_hi_q = b;
        phase_q = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len = (len_hi_q << 8) | b;
        if (width_q == 0 || width_q > MAX_W || len != width_q) err = ERR_LENGTH;
        else begin
          phase_q = PH_COUNT;
          plane_q = 0;
          pos_q = 0;
        end
      end
      PH_COUNT:
        if (b == 0) err = ERR_ZERO;
        else if (b > 128) begin
          span_q = b & 127;
          phase_q = PH_RUN;
        end else begin
          span_q = b;
          phase_q = PH_LIT;
        end
      PH_RUN: begin
        for (int k = 0; k < span_q; k++) begin
          store_byte(b, words, open, ok);
          if (!ok) begin
            err = ERR_OVERRUN;
            break;
          end
        end
        span_q = 0;
        if (err == ERR_NONE) close_span(row_end, frame_end);
      end
      PH_LIT: begin
        store_byte(b, words, open, ok);
        if (!ok) err = ERR_OVERRUN;
        else begin
          span_q = (span_q - 1) & 8'hFF;
          if (span_q == 0) close_span(row_end, frame_end);
        end
      end
      default: begin
        phase_q = PH_MARK_A;
        err = ERR_MARKER;
      end
    endcase
    if (err != ERR_NONE) begin
      halted_q = 1;
      w = '0;
      w.error_code = err;
      words.push_back(w);
    end
    if (words.size() > 0) begin
      w = words[$];
      void'(words.pop_back());
      w.last_of_run = 1;
      w.row_done = row_end;
      w.frame_done = frame_end;
      words.push_back(w);
    end
    foreach (words[i]) pending_words.push_back(words[i]);
  endtask

  // Sends one byte; the prediction is made once it is accepted.
  task automatic send_byte(input logic [7:0] b);
    byte_ch.valid <= 1'b1;
    byte_ch.data <= b;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
    predict_byte(b);
    bytes_sent++;
    // Bursts with random gaps between them.
    if ($urandom_range(0, 3) == 0) begin
      byte_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic go_idle();
    byte_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    // A byte that gives no result may still be in work.
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [0:0] idx, input int unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v[15:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_q = v & 11'h7FF;
    else height_q = v & 16'hFFFF;
  endtask

  task automatic restart_block(input int unsigned w, input int unsigned h);
    go_idle();
    // Errors halt until reset, and reset is given once: a fresh frame
    // only follows completed rows, so no restart is needed otherwise.
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    @(posedge clk);
  endtask

  task automatic send_header(input int unsigned w);
    send_byte(ROW_MARK);
    send_byte(ROW_MARK);
    send_byte(8'(w >> 8));
    send_byte(8'(w));
  endtask

  // One well-formed row with random runs and literals in each plane.
  task automatic send_row(input int unsigned w);
    int unsigned left, n;
    send_header(w);
    for (int pl = 0; pl < 4; pl++) begin
      left = w;
      while (left > 0) begin
        n = $urandom_range(1, (left < 127) ? left : 127);
        if ($urandom_range(0, 1)) begin
          send_byte(8'(128 + n));
          send_byte(8'($urandom));
        end else begin
          if (n > 6) n = $urandom_range(1, 6);
          send_byte(8'(n));
          repeat (n) send_byte(8'($urandom));
        end
        left -= n;
      end
    end
  endtask

  // A wide row made of long runs only, to keep the byte count low.
  task automatic send_wide_row(input int unsigned w);
    int unsigned left, n;
    send_header(w);
    for (int pl = 0; pl < 4; pl++) begin
      left = w;
      while (left > 0) begin
        n = (left < 127) ? left : 127;
        send_byte(8'(128 + n));
        send_byte(8'($urandom));
        left -= n;
      end
    end
  endtask

  task automatic test_directed();
    restart_block(4, 1);
    // Row with extreme bytes: a literal 128 count cannot fit, so 4 literals.
    send_header(4);
    send_byte(8'd132); send_byte(8'hFF);
    send_byte(8'd4); send_byte(8'h00); send_byte(8'h01); send_byte(8'h80); send_byte(8'h7F);
    send_byte(8'd255 & 8'd130); send_byte(8'h55); send_byte(8'd130); send_byte(8'hAA);
    // E plane: zero, tiny exponent (denormal) and largest exponent.
    send_byte(8'd2); send_byte(8'h00); send_byte(8'h01);
    send_byte(8'd130); send_byte(8'hFF);
  endtask

  task automatic test_widths();
    restart_block(1, 2);
    repeat (2) send_row(1);
    go_idle();
    write_reg(REG_WIDTH, MAX_W);
    write_reg(REG_HEIGHT, 0);
    send_wide_row(MAX_W);
  endtask

  task automatic test_random_rows();
    int unsigned w;
    go_idle();
    w = $urandom_range(1, 20);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, $urandom_range(1, 3));
    do begin
      send_row(w);
      if ($urandom_range(0, 3) == 0) begin
        go_idle();
        w = $urandom_range(1, 20);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, $urandom_range(1, 3));
      end
    end while (bytes_sent < 150);
  endtask

  // Ends with a broken row: one error is all the block can give before reset.
  task automatic test_error();
    int unsigned kind;
    kind = $urandom_range(0, 4);
    go_idle();
    write_reg(REG_WIDTH, 3);
    case (kind)
      0: send_byte(8'($urandom_range(3, 255)));
      1: begin send_byte(ROW_MARK); send_byte(ROW_MARK); send_byte(0); send_byte(5); end
      2: begin send_header(3); send_byte(0); end
      3: begin send_header(3); send_byte(8'd2); send_byte(1); send_byte(2);
        send_byte(8'd130); send_byte(9); end
      default: begin
        // Overrun in the E plane while one pixel waits for its partner.
        send_header(3);
        for (int pl = 0; pl < 3; pl++) begin
          send_byte(8'd131); send_byte(8'($urandom));
        end
        send_byte(8'd130); send_byte(8'd9);
        send_byte(8'd130); send_byte(8'd7);
      end
    endcase
    repeat (10) send_byte(8'($urandom));
  endtask

  // Result checker with its own stall pattern.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    res_ch.ready <= !rst && !(($urandom_range(0, 7) < 3) && (cycles % 512 > 128));
    if (!rst && res_ch.valid && res_ch.ready) begin
      words_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected result word");
        errors++;
      end else begin
        result_t e;
        e = pending_words.pop_front();
        if (e.first_red !== res_ch.data.first_red) begin
          $error("first_red exp %h got %h", e.first_red, res_ch.data.first_red); errors++; end
        if (e.first_green !== res_ch.data.first_green) begin
          $error("first_green exp %h got %h", e.first_green, res_ch.data.first_green);
          errors++; end
        if (e.first_blue !== res_ch.data.first_blue) begin
          $error("first_blue exp %h got %h", e.first_blue, res_ch.data.first_blue);
          errors++; end
        if (e.second_red !== res_ch.data.second_red) begin
          $error("second_red exp %h got %h", e.second_red, res_ch.data.second_red);
          errors++; end
        if (e.second_green !== res_ch.data.second_green) begin
          $error("second_green exp %h got %h", e.second_green, res_ch.data.second_green);
          errors++; end
        if (e.second_blue !== res_ch.data.second_blue) begin
          $error("second_blue exp %h got %h", e.second_blue, res_ch.data.second_blue);
          errors++; end
        if (e.pixel_count !== res_ch.data.pixel_count) begin
          $error("pixel_count exp %0d got %0d", e.pixel_count, res_ch.data.pixel_count);
          errors++; end
        if (e.last_of_run !== res_ch.data.last_of_run) begin
          $error("last_of_run exp %0d got %0d", e.last_of_run, res_ch.data.last_of_run);
          errors++; end
        if (e.row_done !== res_ch.data.row_done) begin
          $error("row_done exp %0d got %0d", e.row_done, res_ch.data.row_done); errors++; end
        if (e.frame_done !== res_ch.data.frame_done) begin
          $error("frame_done exp %0d got %0d", e.frame_done, res_ch.data.frame_done);
          errors++; end
        if (e.error_code !== res_ch.data.error_code) begin
          $error("error_code exp %0d got %0d", e.error_code, res_ch.data.error_code);
          errors++; end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.data = '0;
    res_ch.ready = 1'b0;
    width_q = 768; height_q = 1024;
    phase_q = PH_MARK_A;
    plane_q = 0; pos_q = 0; span_q = 0; len_hi_q = 0; rows_q = 0; halted_q = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_widths();
    test_random_rows();
    test_error();
    go_idle();
    $display("Sent %0d bytes over widths 1 to %0d, rows, frames and one error; %0d words checked.",
             bytes_sent, MAX_W, words_seen);
    if (errors == 0 && pending_words.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

### files.f
src/rgbe_pkg.sv
src/rgbe_stream_if.sv
src/rgbe_res_if.sv
src/rgbe_rle_scanline_decoder.sv
tb/rgbe_rle_scanline_decoder_tb.sv
